// ===== design/up_down_potentiometer_stepper_core_macros.svh =====
// Assertion macros for the up/down potentiometer stepper checker.
`ifndef UP_DOWN_POTENTIOMETER_STEPPER_CORE_MACROS_SVH
`define UP_DOWN_POTENTIOMETER_STEPPER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define UDPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define UDPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/udps_pkg.sv =====
// Shared types and constants of the up/down potentiometer stepper.
package udps_pkg;

  localparam int CMD_W       = 2;
  localparam int STEP_W      = 9;
  localparam int TARGET_W    = 8;
  localparam int POS_W       = 7;
  localparam int DELTA_W     = 10;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ABS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INC_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESELECT = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = 7'd99;

  typedef struct packed {
    logic              abs_move;
    logic [STEP_W-1:0] arg;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic queue_empty;
    logic command_dropped;
  } q_status_t;

  typedef struct packed {
    logic [TICK_W-1:0] inc_low;
    logic [TICK_W-1:0] inc_high;
    logic [TICK_W-1:0] deselect;
  } cfg_t;

  typedef struct packed {
    logic             up_direction;
    logic             chip_select_n;
    logic             increment_level;
    logic [POS_W-1:0] wiper_position;
  } pins_t;

endpackage

// ===== design/udps_front.sv =====
// Command classifier and command queue of the potentiometer stepper.
module udps_front #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_fire,
  input  logic [udps_pkg::CMD_W-1:0]         command,
  input  logic signed [udps_pkg::STEP_W-1:0] step_count,
  input  logic [udps_pkg::TARGET_W-1:0]      target_position,
  input  logic                               deq,
  output udps_pkg::q_head_t                  head,
  output udps_pkg::q_status_t                status
);
  import udps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  q_entry_t             mem [QUEUE_DEPTH];
  q_entry_t             head_r;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  q_entry_t             new_entry;
  logic                 has_cmd;
  logic                 enq;
  logic [POS_W-1:0]     clamped;

  always_comb begin
    clamped = (target_position > TARGET_W'(POS_MAX)) ? POS_MAX : target_position[POS_W-1:0];
    has_cmd = 1'b0;
    new_entry = '0;
    unique case (command)
      CMD_REL: begin
        has_cmd = 1'b1;
        new_entry.abs_move = 1'b0;
        new_entry.arg = step_count;
      end
      CMD_ABS: begin
        has_cmd = 1'b1;
        new_entry.abs_move = 1'b1;
        new_entry.arg = {{(STEP_W - POS_W){1'b0}}, clamped};
      end
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

  assign enq = in_fire && has_cmd && (count_r != CNT_FULL);

  assign head.valid = (count_r != '0) || enq;
  assign head.entry = (count_r == '0) ? new_entry : head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(enq) - CNT_W'(deq);
  end

  assign status.queue_empty     = (count_nxt == '0);
  assign status.command_dropped = in_fire && has_cmd && (count_r == CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (enq && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= new_entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

// ===== design/udps_seq.sv =====
// Pulse sequencer that drives the potentiometer lines and tracks the wiper.
module udps_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  udps_pkg::cfg_t      cfg,
  input  udps_pkg::q_head_t   head,
  output logic                deq,
  output udps_pkg::pins_t     pins_nxt
);
  import udps_pkg::*;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_SELECT = 3'd1;
  localparam logic [2:0] PH_BEGIN  = 3'd2;
  localparam logic [2:0] PH_LOW    = 3'd3;
  localparam logic [2:0] PH_HIGH   = 3'd4;
  localparam logic [2:0] PH_DESEL  = 3'd5;

  logic [2:0]                 phase_r, phase_nxt;
  logic signed [DELTA_W-1:0]  delta_r, delta_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [TICK_W-1:0]          elapsed_r, elapsed_nxt;
  logic                       dir_r, dir_nxt;
  logic                       sel_r, sel_nxt;
  logic                       inc_r, inc_nxt;
  logic [TICK_W-1:0]          elapsed_inc;
  logic                       delta_pos;
  logic signed [DELTA_W-1:0]  delta_step;
  logic signed [DELTA_W-1:0]  new_delta;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign delta_pos   = !delta_r[DELTA_W-1] && (delta_r != '0);
  assign delta_step  = delta_pos ? delta_r - 1'b1 : delta_r + 1'b1;

  always_comb begin
    if (head.entry.abs_move) begin
      new_delta = $signed({3'b000, head.entry.arg[POS_W-1:0]}) - $signed({3'b000, pos_r});
    end else begin
      new_delta = {head.entry.arg[STEP_W-1], head.entry.arg};
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    delta_nxt   = delta_r;
    pos_nxt     = pos_r;
    elapsed_nxt = elapsed_r;
    dir_nxt     = dir_r;
    sel_nxt     = sel_r;
    inc_nxt     = inc_r;
    deq         = 1'b0;
    unique case (phase_r)
      PH_SELECT: begin
        dir_nxt   = delta_pos;
        sel_nxt   = 1'b0;
        phase_nxt = PH_BEGIN;
      end
      PH_BEGIN: begin
        inc_nxt     = 1'b0;
        phase_nxt   = PH_LOW;
        elapsed_nxt = '0;
      end
      PH_LOW: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= cfg.inc_low) begin
          if (delta_pos) begin
            pos_nxt = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;
          end else begin
            pos_nxt = (pos_r != '0) ? pos_r - 1'b1 : pos_r;
          end
          delta_nxt = delta_step;
          if (delta_step == '0) begin
            sel_nxt   = 1'b1;
            phase_nxt = PH_DESEL;
          end else begin
            phase_nxt = PH_HIGH;
          end
          inc_nxt     = 1'b1;
          elapsed_nxt = '0;
        end
      end
      PH_HIGH: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= cfg.inc_high) begin
          inc_nxt     = 1'b0;
          phase_nxt   = PH_LOW;
          elapsed_nxt = '0;
        end
      end
      PH_DESEL: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= cfg.deselect) begin
          phase_nxt = PH_START;
        end
      end
      default: begin
        phase_nxt = PH_START;
        if (head.valid) begin
          deq       = step_en;
          delta_nxt = new_delta;
          if (new_delta != '0) begin
            phase_nxt = PH_SELECT;
          end
        end
      end
    endcase
  end

  assign pins_nxt.up_direction    = dir_nxt;
  assign pins_nxt.chip_select_n   = sel_nxt;
  assign pins_nxt.increment_level = inc_nxt;
  assign pins_nxt.wiper_position  = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      delta_r   <= '0;
      pos_r     <= '0;
      elapsed_r <= '0;
      dir_r     <= 1'b0;
      sel_r     <= 1'b1;
      inc_r     <= 1'b1;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      delta_r   <= delta_nxt;
      pos_r     <= pos_nxt;
      elapsed_r <= elapsed_nxt;
      dir_r     <= dir_nxt;
      sel_r     <= sel_nxt;
      inc_r     <= inc_nxt;
    end
  end

endmodule

// ===== design/udps_obuf.sv =====
// Two-entry output buffer that decouples the result stream from the tick input.
module udps_obuf (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [udps_pkg::OUT_TDATA_W-1:0] push_data,
  output logic                             push_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [udps_pkg::OUT_TDATA_W-1:0] out_data
);
  import udps_pkg::*;

  logic                   v0_r, v1_r;
  logic [OUT_TDATA_W-1:0] d0_r, d1_r;
  logic                   pop;

  assign pop        = v0_r && out_ready;
  assign push_ready = !v1_r;
  assign out_valid  = v0_r;
  assign out_data   = d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      priority if (pop && push) begin
        v0_r <= 1'b1;
      end else if (push) begin
        if (v0_r) begin
          v1_r <= 1'b1;
        end else begin
          v0_r <= 1'b1;
        end
      end else if (pop) begin
        if (v1_r) begin
          v1_r <= 1'b0;
        end else begin
          v0_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && push) begin
      d0_r <= push_data;
    end else if (push) begin
      if (v0_r) begin
        d1_r <= push_data;
      end else begin
        d0_r <= push_data;
      end
    end else if (pop) begin
      d0_r <= d1_r;
    end
  end

endmodule

// ===== design/up_down_potentiometer_stepper_core.sv =====
// Top level of the up/down digital potentiometer stepper.
//
// Each request on the in_ channel is one timer tick; in_tuser selects tick only,
// a relative move (step_count) or an absolute move (target_position, clamped
// to 99). Moves wait in a command queue of QUEUE_DEPTH entries; a request that
// finds the queue full is dropped and flagged in its result.
// Every tick first queues its move, then advances the pulse sequencer by one
// step, and produces exactly one result on the out_ channel: the three line
// levels, the tracked wiper position, the queue-empty flag and the drop flag.
// A result is registered in the output buffer when its request is accepted.
// Throughput: one request per cycle while in_tready is high; the sequencer and
// the queue both advance in the accepting cycle, so nothing else limits the rate.
// A two-entry output buffer lets a new request in while one result waits;
// in_tready falls only when two results are held by a stalled receiver.
// cfg_ writes set the low, high and deselect times in ticks (reset value 1)
// and are always ready; write them only while the block is idle.
// Reset: wiper 0, chip deselected, increment high, direction down, queue empty.
module up_down_potentiometer_stepper_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [8:0] step_count, [16:9] target_position, [23:17] zero
  input  logic [udps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [udps_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] up_direction, [1] chip_select_n, [2] increment_level,
  // [9:3] wiper_position, [10] queue_empty, [11] command_dropped, [15:12] zero
  output logic [udps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [udps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [udps_pkg::TICK_W-1:0]      cfg_data
);
  import udps_pkg::*;

  cfg_t                   cfg_r;
  logic                   in_fire;
  logic                   deq;
  q_head_t                head;
  q_status_t              status;
  pins_t                  pins_nxt;
  logic [OUT_TDATA_W-1:0] result;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inc_low  <= TICK_W'(1);
      cfg_r.inc_high <= TICK_W'(1);
      cfg_r.deselect <= TICK_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INC_LOW:  cfg_r.inc_low  <= cfg_data;
        REG_INC_HIGH: cfg_r.inc_high <= cfg_data;
        REG_DESELECT: cfg_r.deselect <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  udps_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .command         (in_tuser[CMD_W-1:0]),
    .step_count      (in_tdata[STEP_W-1:0]),
    .target_position (in_tdata[STEP_W+TARGET_W-1:STEP_W]),
    .deq             (deq),
    .head            (head),
    .status          (status)
  );

  udps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_fire),
    .cfg      (cfg_r),
    .head     (head),
    .deq      (deq),
    .pins_nxt (pins_nxt)
  );

  assign result = {4'b0000, status.command_dropped, status.queue_empty,
                   pins_nxt.wiper_position, pins_nxt.increment_level,
                   pins_nxt.chip_select_n, pins_nxt.up_direction};

  udps_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (result),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

// ===== design/udps_checker.sv =====
// Port-level checker for the potentiometer stepper and its bind.
`include "up_down_potentiometer_stepper_core_macros.svh"

module udps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [udps_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import udps_pkg::*;

  `UDPS_ASSERT_SAME(a_wiper_range, clk, rst_n, out_tvalid, out_tdata[9:3] <= POS_MAX, "wiper out of range")
  `UDPS_ASSERT_SAME(a_drop_full, clk, rst_n, out_tvalid && out_tdata[11], !out_tdata[10], "drop with empty queue")
  `UDPS_ASSERT_SAME(a_desel_inc_high, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[2], "increment low while deselected")
  `UDPS_ASSERT_SAME(a_ready_skid, clk, rst_n, !in_tready, out_tvalid, "input stalled with no pending result")
  `UDPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind up_down_potentiometer_stepper_core udps_checker u_udps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
